FILE: hdl/qped_pkg.sv
// Package: shared types, constants and helpers of the query parameter decoder.
`default_nettype none
package qped_pkg;

   localparam int VALUE_DEPTH = 64;
   localparam int KEY_BYTES   = 8;
   localparam int FIFO_DEPTH  = 2;

   localparam int ADDR_W = $clog2(VALUE_DEPTH);
   localparam int CNT_W  = $clog2(VALUE_DEPTH + 1);
   localparam int KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

   localparam int NAME_W = 64;
   localparam int PLEN_W = 4;
   localparam int CAP_W  = 7;
   localparam int RAW_W  = 7;
   localparam int KCNT_W = 4;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   localparam logic [1:0] REG_PARAM_NAME     = 2'd0;
   localparam logic [1:0] REG_PARAM_LENGTH   = 2'd1;
   localparam logic [1:0] REG_VALUE_CAPACITY = 2'd2;

   localparam logic [7:0] CHAR_PCT   = 8'h25;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_EQ    = 8'h3D;
   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam int         HEX_RADIX  = 16;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } store_wr_type;

   typedef struct packed {
      logic             found;
      logic             has_bytes;
      logic [CNT_W-1:0] count;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic emitting;
   } back_status_type;

   // Return {valid, digit value} for an ASCII hex digit.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c inside {[8'h61:8'h66]}) begin
         r = {1'b1, 4'(c - 8'h61 + 8'd10)};
      end else if (c inside {[8'h41:8'h46]}) begin
         r = {1'b1, 4'(c - 8'h41 + 8'd10)};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/qped_front.sv
// Front end: csr registers, key scan, percent decode and value store writes.
`default_nettype none
module qped_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [7:0]                req_tdata,
   input  wire logic                      req_tlast,
   input  wire logic                      csr_wr_en,
   input  wire logic [1:0]                csr_index,
   input  wire logic [63:0]               csr_wr_data,
   input  wire logic                      fifo_full,
   input  wire qped_pkg::back_status_type back_status,
   output logic                           cmd_push,
   output qped_pkg::cmd_type              cmd_data,
   output qped_pkg::store_wr_type         store_wr
);

   localparam logic [1:0] MODE_KEY   = 2'd0;
   localparam logic [1:0] MODE_MATCH = 2'd1;
   localparam logic [1:0] MODE_SKIP  = 2'd2;
   localparam logic [1:0] MODE_DRAIN = 2'd3;

   localparam logic [1:0] ESC_NONE  = 2'd0;
   localparam logic [1:0] ESC_PCT   = 2'd1;
   localparam logic [1:0] ESC_DIGIT = 2'd2;

   localparam int NSLOT = 4;

   logic [qped_pkg::NAME_W-1:0] name_ff;
   logic [qped_pkg::PLEN_W-1:0] plen_ff;
   logic [qped_pkg::CAP_W-1:0]  cap_ff;

   logic [1:0]                  mode_ff, mode_in;
   logic [qped_pkg::KCNT_W-1:0] kcount_ff, kcount_in;
   logic                        kequal_ff, kequal_in;
   logic [qped_pkg::RAW_W-1:0]  raw_ff, raw_in;
   logic [1:0]                  phase_ff, phase_in;
   logic [7:0]                  held_ff, held_in;
   logic [qped_pkg::CNT_W-1:0]  dec_ff, dec_in;

   logic                        busy_ff, busy_in;
   logic                        cpend_ff, cpend_in;
   qped_pkg::cmd_type           cpend_data_ff, cpend_data_in;
   logic [1:0]                  pend_n_ff, pend_n_in;
   logic [7:0]                  pend_data_ff [NSLOT-1];
   logic [qped_pkg::ADDR_W-1:0] pend_addr_ff [NSLOT-1];

   logic                        accept;
   logic [7:0]                  c;
   logic [4:0]                  hex_c, hex_h;
   logic                        hit, consumed;
   logic                        end_v, end_last, end_match, nf, newkey, drain;
   logic [7:0]                  cand [NSLOT];
   logic [2:0]                  nc, nw;
   logic [7:0]                  w_data [NSLOT];
   logic [qped_pkg::ADDR_W-1:0] w_addr [NSLOT];
   logic [qped_pkg::CNT_W-1:0]  dec;
   logic [qped_pkg::CAP_W-1:0]  limit;
   logic [7:0]                  key_byte;
   logic                        cmd_v;
   qped_pkg::cmd_type           cmd_now;
   logic                        push_now;

   assign accept = req_tvalid && req_tready;
   assign c      = req_tdata;
   assign hex_c  = qped_pkg::hex_digit(c);
   assign hex_h  = qped_pkg::hex_digit(held_ff);
   assign limit  = (cap_ff < qped_pkg::CAP_W'(qped_pkg::VALUE_DEPTH)) ?
                   cap_ff : qped_pkg::CAP_W'(qped_pkg::VALUE_DEPTH);
   assign key_byte = name_ff[8*kcount_ff[qped_pkg::KIDX_W-1:0] +: 8];

   // Hold input while writes or a result command are pending, or while a stored
   // value is still queued or being emitted and this byte could overwrite it.
   assign req_tready = (pend_n_ff == 2'd0) && !cpend_ff &&
                       !(busy_ff && (mode_ff == MODE_MATCH));

   always_comb begin
      mode_in   = mode_ff;
      kcount_in = kcount_ff;
      kequal_in = kequal_ff;
      raw_in    = raw_ff;
      phase_in  = phase_ff;
      held_in   = held_ff;
      dec_in    = dec_ff;
      hit       = 1'b0;
      consumed  = 1'b0;
      end_v     = 1'b0;
      end_last  = 1'b0;
      end_match = 1'b0;
      nf        = 1'b0;
      newkey    = 1'b0;
      drain     = 1'b0;
      nc        = 3'd0;
      nw        = 3'd0;
      cmd_v     = 1'b0;
      cmd_now   = '0;
      for (int i = 0; i < NSLOT; i++) begin
         cand[i]   = 8'd0;
         w_data[i] = 8'd0;
         w_addr[i] = '0;
      end

      case (mode_ff)
         MODE_KEY: begin
            if (c == qped_pkg::CHAR_EQ) begin
               hit      = kequal_ff && (kcount_ff == plen_ff);
               raw_in   = '0;
               dec_in   = '0;
               phase_in = ESC_NONE;
               mode_in  = hit ? MODE_MATCH : MODE_SKIP;
               if (req_tlast) begin
                  end_v     = 1'b1;
                  end_last  = 1'b1;
                  end_match = hit;
               end
            end else begin
               if (kcount_ff >= qped_pkg::KCNT_W'(plen_ff) ||
                   kcount_ff >= qped_pkg::KCNT_W'(qped_pkg::KEY_BYTES) ||
                   key_byte != c) begin
                  kequal_in = 1'b0;
               end
               if (kcount_ff != '1) kcount_in = kcount_ff + 1'b1;
               if (req_tlast) nf = 1'b1;
            end
         end
         MODE_MATCH: begin
            if (c == qped_pkg::CHAR_AMP) begin
               end_v     = 1'b1;
               end_last  = req_tlast;
               end_match = 1'b1;
            end else begin
               if (raw_ff != '1) raw_in = raw_ff + 1'b1;
               // Second and third escape characters: keep the digit, complete the byte or give up.
               if (phase_ff == ESC_PCT) begin
                  if (hex_c[4]) begin
                     held_in  = c;
                     phase_in = ESC_DIGIT;
                     consumed = 1'b1;
                  end
               end else if (phase_ff == ESC_DIGIT) begin
                  if (hex_c[4] && hex_h[4]) begin
                     cand[nc[1:0]] = {hex_h[3:0], hex_c[3:0]};
                     nc            = nc + 3'd1;
                     phase_in      = ESC_NONE;
                     consumed      = 1'b1;
                  end
               end
               // Bad escape: pass the pending characters through literally.
               if (!consumed && phase_ff != ESC_NONE) begin
                  cand[nc[1:0]] = qped_pkg::CHAR_PCT;
                  nc            = nc + 3'd1;
                  if (phase_ff == ESC_DIGIT) begin
                     cand[nc[1:0]] = held_ff;
                     nc            = nc + 3'd1;
                  end
                  phase_in = ESC_NONE;
               end
               if (!consumed) begin
                  if (c == qped_pkg::CHAR_PCT) begin
                     phase_in = ESC_PCT;
                  end else if (c == qped_pkg::CHAR_PLUS) begin
                     cand[nc[1:0]] = qped_pkg::CHAR_SPACE;
                     nc            = nc + 3'd1;
                  end else begin
                     cand[nc[1:0]] = c;
                     nc            = nc + 3'd1;
                  end
               end
               if (req_tlast) begin
                  end_v     = 1'b1;
                  end_last  = 1'b1;
                  end_match = 1'b1;
               end
            end
         end
         MODE_SKIP: begin
            if (req_tlast) nf = 1'b1;
            else if (c == qped_pkg::CHAR_AMP) newkey = 1'b1;
         end
         default: begin
            if (req_tlast) newkey = 1'b1;
         end
      endcase

      // Escape cut off by the value's end.
      if (end_v && end_match) begin
         if (phase_in != ESC_NONE) begin
            cand[nc[1:0]] = qped_pkg::CHAR_PCT;
            nc            = nc + 3'd1;
         end
         if (phase_in == ESC_DIGIT) begin
            cand[nc[1:0]] = held_in;
            nc            = nc + 3'd1;
         end
         phase_in = ESC_NONE;
      end

      // Place the candidate bytes in the store; drop those beyond its depth.
      dec = dec_in;
      for (int i = 0; i < NSLOT; i++) begin
         if (3'(i) < nc && dec < qped_pkg::CNT_W'(qped_pkg::VALUE_DEPTH)) begin
            w_data[nw[1:0]] = cand[i];
            w_addr[nw[1:0]] = dec[qped_pkg::ADDR_W-1:0];
            nw              = nw + 3'd1;
            dec             = dec + 1'b1;
         end
      end
      dec_in = dec;

      if (end_v) begin
         if (end_match && (raw_in < limit)) begin
            cmd_v             = 1'b1;
            cmd_now.found     = 1'b1;
            cmd_now.has_bytes = (dec != '0);
            cmd_now.count     = dec;
            newkey            = 1'b1;
            drain             = !end_last;
         end else if (end_last) begin
            nf = 1'b1;
         end else begin
            newkey = 1'b1;
         end
      end
      if (nf) begin
         cmd_v   = 1'b1;
         cmd_now = '0;
         newkey  = 1'b1;
      end
      if (newkey) begin
         mode_in   = drain ? MODE_DRAIN : MODE_KEY;
         kcount_in = '0;
         kequal_in = 1'b1;
         raw_in    = '0;
         phase_in  = ESC_NONE;
         held_in   = 8'd0;
         dec_in    = '0;
      end
   end

   // Result command: push now when no write is left over and the queue is not full, else hold it.
   assign push_now = accept && cmd_v && (nw <= 3'd1) && !fifo_full;
   assign cmd_push = (cpend_ff && (pend_n_ff == 2'd0) && !fifo_full) || push_now;
   assign cmd_data = cpend_ff ? cpend_data_ff : cmd_now;

   always_comb begin
      cpend_in      = cpend_ff;
      cpend_data_in = cpend_data_ff;
      if (cpend_ff && (pend_n_ff == 2'd0) && !fifo_full) cpend_in = 1'b0;
      if (accept && cmd_v && !push_now) begin
         cpend_in      = 1'b1;
         cpend_data_in = cmd_now;
      end
      busy_in = busy_ff;
      if (back_status.done) busy_in = 1'b0;
      if (cmd_push && cmd_data.has_bytes) busy_in = 1'b1;
      pend_n_in = pend_n_ff;
      if (pend_n_ff != 2'd0) pend_n_in = pend_n_ff - 2'd1;
      else if (accept && nw != 3'd0) pend_n_in = 2'(nw - 3'd1);
   end

   always_comb begin
      store_wr = '0;
      if (pend_n_ff != 2'd0) begin
         store_wr.en   = 1'b1;
         store_wr.addr = pend_addr_ff[0];
         store_wr.data = pend_data_ff[0];
      end else if (accept && nw != 3'd0) begin
         store_wr.en   = 1'b1;
         store_wr.addr = w_addr[0];
         store_wr.data = w_data[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_ff   <= '0;
         plen_ff   <= '0;
         cap_ff    <= qped_pkg::CAP_RESET;
         mode_ff   <= MODE_KEY;
         kcount_ff <= '0;
         kequal_ff <= 1'b1;
         raw_ff    <= '0;
         phase_ff  <= ESC_NONE;
         held_ff   <= 8'd0;
         dec_ff    <= '0;
         busy_ff   <= 1'b0;
         cpend_ff  <= 1'b0;
         pend_n_ff <= 2'd0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               qped_pkg::REG_PARAM_NAME:     name_ff <= csr_wr_data;
               qped_pkg::REG_PARAM_LENGTH:   plen_ff <= csr_wr_data[qped_pkg::PLEN_W-1:0];
               qped_pkg::REG_VALUE_CAPACITY: cap_ff  <= csr_wr_data[qped_pkg::CAP_W-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            mode_ff   <= mode_in;
            kcount_ff <= kcount_in;
            kequal_ff <= kequal_in;
            raw_ff    <= raw_in;
            phase_ff  <= phase_in;
            held_ff   <= held_in;
            dec_ff    <= dec_in;
         end
         busy_ff   <= busy_in;
         cpend_ff  <= cpend_in;
         pend_n_ff <= pend_n_in;
      end
   end

   always_ff @(posedge clock) begin
      cpend_data_ff <= cpend_data_in;
      if (pend_n_ff != 2'd0) begin
         for (int i = 0; i < NSLOT - 2; i++) begin
            pend_data_ff[i] <= pend_data_ff[i+1];
            pend_addr_ff[i] <= pend_addr_ff[i+1];
         end
      end else if (accept) begin
         for (int i = 0; i < NSLOT - 1; i++) begin
            pend_data_ff[i] <= w_data[i+1];
            pend_addr_ff[i] <= w_addr[i+1];
         end
      end
   end

endmodule
`default_nettype wire

FILE: hdl/qped_cmd_fifo.sv
// Short command queue between the front end and the result emitter.
`default_nettype none
module qped_cmd_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire qped_pkg::cmd_type push_data,
   input  wire logic              pop,
   output qped_pkg::cmd_type      pop_data,
   output logic                   full,
   output logic                   nonempty
);

   localparam int PTR_W = (qped_pkg::FIFO_DEPTH > 1) ? $clog2(qped_pkg::FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(qped_pkg::FIFO_DEPTH + 1);

   qped_pkg::cmd_type slot_ff [qped_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0]  wptr_ff, wptr_in;
   logic [PTR_W-1:0]  rptr_ff, rptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full     = (count_ff == CNT_W'(qped_pkg::FIFO_DEPTH));
   assign nonempty = (count_ff != '0);
   assign pop_data = slot_ff[rptr_ff];

   // Advance a pointer and wrap it at the queue depth.
   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == PTR_W'(qped_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
      return r;
   endfunction

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) wptr_in = bump(wptr_ff);
      if (pop) rptr_in = bump(rptr_ff);
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wptr_ff] <= push_data;
   end

endmodule
`default_nettype wire

FILE: hdl/qped_back.sv
// Back end: value store memory and result emitter.
`default_nettype none
module qped_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire qped_pkg::store_wr_type store_wr,
   input  wire logic                   cmd_valid,
   input  wire qped_pkg::cmd_type      cmd_data,
   output logic                        cmd_pop,
   output qped_pkg::back_status_type   back_status,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [7:0]                  rsp_tdata,
   output logic [1:0]                  rsp_tuser,
   output logic                        rsp_tlast
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SHOW = 1'b1;

   logic [7:0]                  store_mem [qped_pkg::VALUE_DEPTH];
   logic [7:0]                  rd_data_ff;
   logic                        rd_en;
   logic [qped_pkg::ADDR_W-1:0] rd_addr;

   logic                       state_ff, state_in;
   logic                       found_ff, found_in;
   logic                       bytes_ff, bytes_in;
   logic [qped_pkg::CNT_W-1:0] count_ff, count_in;
   logic [qped_pkg::CNT_W-1:0] k_ff, k_in;
   logic [qped_pkg::CNT_W-1:0] k_next;
   logic                       is_last, take;

   assign k_next  = k_ff + 1'b1;
   assign is_last = !bytes_ff || (k_next == count_ff);
   assign take    = (state_ff == ST_SHOW) && rsp_tready;
   assign cmd_pop = (state_ff == ST_IDLE) && cmd_valid;

   assign rsp_tvalid = (state_ff == ST_SHOW);
   assign rsp_tdata  = bytes_ff ? rd_data_ff : 8'd0;
   assign rsp_tuser  = {found_ff, bytes_ff};
   assign rsp_tlast  = is_last;

   assign back_status.done     = take && bytes_ff && is_last;
   assign back_status.emitting = (state_ff == ST_SHOW) && bytes_ff;

   always_comb begin
      state_in = state_ff;
      found_in = found_ff;
      bytes_in = bytes_ff;
      count_in = count_ff;
      k_in     = k_ff;
      rd_en    = 1'b0;
      rd_addr  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               state_in = ST_SHOW;
               found_in = cmd_data.found;
               bytes_in = cmd_data.has_bytes;
               count_in = cmd_data.count;
               k_in     = '0;
               rd_en    = cmd_data.has_bytes;
            end
         end
         ST_SHOW: begin
            if (take) begin
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  // Fetch the next byte as this one leaves.
                  k_in    = k_next;
                  rd_en   = 1'b1;
                  rd_addr = k_next[qped_pkg::ADDR_W-1:0];
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         found_ff <= 1'b0;
         bytes_ff <= 1'b0;
         count_ff <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         found_ff <= found_in;
         bytes_ff <= bytes_in;
         count_ff <= count_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_wr.en) store_mem[store_wr.addr] <= store_wr.data;
      if (rd_en) rd_data_ff <= store_mem[rd_addr];
   end

endmodule
`default_nettype wire

FILE: hdl/query_param_extract_decode_unit.sv
// Top level of the URL query parameter extractor with percent decoding.
//
// Usage: a query string streams in on req_* one byte per transaction,
// req_tlast on its final byte. The csr_* port selects the wanted key
// (index 0 name bytes, 1 key length, 2 value capacity); write it only while
// the block is idle. When the matching value ends ('&' or the last byte) and
// its raw length is below the capacity (clamped to the store depth, 64), its
// decoded bytes leave on rsp_* one per transaction, rsp_tlast on the final
// one; an empty value gives one result with byte_valid low. A query without
// an accepted value gives one not-found result at its last byte.
// Throughput: one query byte per cycle. A byte that emits more than one
// decoded byte into the value store (up to three) holds req_tready low while
// the extra bytes are written, and while its result command waits if it also
// closes an answer; the single write port of the store sets this. Value bytes
// of a new match wait while a previous value is queued or read out of the store.
// Results: the command of an ending byte passes the command queue and the
// emitter's store read register; bytes then leave one per cycle while
// rsp_tready stays high, and the emitter goes idle between answers.
// A stalled receiver holds the result in place; the two-entry command queue
// lets the front keep scanning until it is full or a value byte needs the store.
// Reset (synchronous) returns to key scanning with the csr defaults and an
// empty queue; the value store needs no clearing.
`default_nettype none
module query_param_extract_decode_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // Query input channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] query_byte
   input  wire logic        req_tlast,   // query_last
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] value_byte
   output logic [1:0]       rsp_tuser,   // [0] byte_valid, [1] found
   output logic             rsp_tlast,   // value_last
   // Configuration write port.
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_wr_data
);

   qped_pkg::store_wr_type    store_wr;
   qped_pkg::cmd_type         push_data;
   qped_pkg::cmd_type         pop_data;
   qped_pkg::back_status_type back_status;
   logic                      cmd_push, cmd_pop, fifo_full, fifo_nonempty;

   // Scan keys, decode the value and queue one command per answer.
   qped_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .fifo_full   (fifo_full),
      .back_status (back_status),
      .cmd_push    (cmd_push),
      .cmd_data    (push_data),
      .store_wr    (store_wr)
   );

   // Decouple scanning from emission.
   qped_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (push_data),
      .pop       (cmd_pop),
      .pop_data  (pop_data),
      .full      (fifo_full),
      .nonempty  (fifo_nonempty)
   );

   // Hold the store and replay it as result transactions.
   qped_back u_back (
      .clock       (clock),
      .reset       (reset),
      .store_wr    (store_wr),
      .cmd_valid   (fifo_nonempty),
      .cmd_data    (pop_data),
      .cmd_pop     (cmd_pop),
      .back_status (back_status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   // The store is never written while a value is being read out of it.
   a_no_write_during_emit: assert property (@(posedge clock) disable iff (reset)
      !(store_wr.en && back_status.emitting))
      else $error("value store written while emitting");

   // A command is never pushed into a full queue.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !fifo_full)
      else $error("command pushed into full queue");

   // A data byte only comes with a found answer.
   a_byte_implies_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> rsp_tuser[1])
      else $error("byte_valid without found");

   // Results without a byte carry a zero byte and end the answer.
   a_empty_result_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == 8'd0 && rsp_tlast))
      else $error("malformed empty or not-found result");

endmodule
`default_nettype wire
